@@ rtl/prs80_pkg.sv @@
// Shared types, constants and round functions of the PRESENT-80 cipher core.
`default_nettype none

package prs80_pkg;

    localparam int unsigned ROUNDS_DEFAULT = 31;
    localparam int unsigned BLOCK_W        = 64;
    localparam int unsigned KEY_W          = 80;
    localparam int unsigned KEY_HIGH_W     = 16;
    localparam int unsigned RC_W           = 5;
    localparam int unsigned APB_DATA_W     = 64;
    localparam int unsigned APB_ADDR_W     = 4;

    // Register index, taken from the doubleword address bit.
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [RC_W-1:0]    rc_t;

    typedef struct packed {
        logic valid;
        logic kind;
    } stage_ctrl_t;

    function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0:    y = 4'hC;
            4'h1:    y = 4'h5;
            4'h2:    y = 4'h6;
            4'h3:    y = 4'hB;
            4'h4:    y = 4'h9;
            4'h5:    y = 4'h0;
            4'h6:    y = 4'hA;
            4'h7:    y = 4'hD;
            4'h8:    y = 4'h3;
            4'h9:    y = 4'hE;
            4'hA:    y = 4'hF;
            4'hB:    y = 4'h8;
            4'hC:    y = 4'h4;
            4'hD:    y = 4'h7;
            4'hE:    y = 4'h1;
            default: y = 4'h2;
        endcase
        return y;
    endfunction

    function automatic logic [3:0] sbox_bwd(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0:    y = 4'h5;
            4'h1:    y = 4'hE;
            4'h2:    y = 4'hF;
            4'h3:    y = 4'h8;
            4'h4:    y = 4'hC;
            4'h5:    y = 4'h1;
            4'h6:    y = 4'h2;
            4'h7:    y = 4'hD;
            4'h8:    y = 4'hB;
            4'h9:    y = 4'h4;
            4'hA:    y = 4'h6;
            4'hB:    y = 4'h3;
            4'hC:    y = 4'h0;
            4'hD:    y = 4'h7;
            4'hE:    y = 4'h9;
            default: y = 4'hA;
        endcase
        return y;
    endfunction

    function automatic block_t sub_fwd(input block_t x);
        block_t r;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            r[4*n +: 4] = sbox_fwd(x[4*n +: 4]);
        end
        return r;
    endfunction

    function automatic block_t sub_inv(input block_t x);
        block_t r;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            r[4*n +: 4] = sbox_bwd(x[4*n +: 4]);
        end
        return r;
    endfunction

    // Bit i moves to 16*i mod 63; the top bit stays.
    function automatic block_t perm_fwd(input block_t x);
        block_t r;
        r[BLOCK_W-1] = x[BLOCK_W-1];
        for (int i = 0; i < BLOCK_W - 1; i++) begin
            r[(i * 16) % (BLOCK_W - 1)] = x[i];
        end
        return r;
    endfunction

    // Bit i moves to 4*i mod 63; the top bit stays.
    function automatic block_t perm_inv(input block_t x);
        block_t r;
        r[BLOCK_W-1] = x[BLOCK_W-1];
        for (int i = 0; i < BLOCK_W - 1; i++) begin
            r[(i * 4) % (BLOCK_W - 1)] = x[i];
        end
        return r;
    endfunction

    function automatic block_t top_key(input key_t k);
        return k[KEY_W-1 -: BLOCK_W];
    endfunction

    // Rotate left by 61, substitute the top nibble, mix in the round counter.
    function automatic key_t key_fwd(input key_t k, input rc_t rc);
        key_t r;
        r = {k[18:0], k[KEY_W-1:19]};
        r[KEY_W-1 -: 4] = sbox_fwd(r[KEY_W-1 -: 4]);
        r[19:15] = r[19:15] ^ rc;
        return r;
    endfunction

    function automatic key_t key_bwd(input key_t k, input rc_t rc);
        key_t r;
        r = k;
        r[19:15] = r[19:15] ^ rc;
        r[KEY_W-1 -: 4] = sbox_bwd(r[KEY_W-1 -: 4]);
        r = {r[60:0], r[KEY_W-1:61]};
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/prs80_round.sv @@
// One registered cipher round, encrypt or decrypt chosen per beat.
`default_nettype none

module prs80_round #(
    parameter logic [prs80_pkg::RC_W-1:0] RC_ENC = '0,
    parameter logic [prs80_pkg::RC_W-1:0] RC_DEC = '0,
    parameter bit                         LAST   = 1'b0
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     advance,
    input  prs80_pkg::stage_ctrl_t  ctrl_in,
    input  prs80_pkg::block_t       data_in,
    input  prs80_pkg::key_t         key_in,
    output prs80_pkg::stage_ctrl_t  ctrl_out,
    output prs80_pkg::block_t       data_out,
    output prs80_pkg::key_t         key_out
);

    prs80_pkg::stage_ctrl_t ctrl_reg;
    prs80_pkg::block_t      data_reg;
    prs80_pkg::block_t      data_next;
    prs80_pkg::key_t        key_reg;
    prs80_pkg::key_t        key_next;

    prs80_pkg::block_t      enc_data;
    prs80_pkg::key_t        enc_key;
    prs80_pkg::block_t      dec_data;
    prs80_pkg::key_t        dec_key;

    always_comb
    begin
        enc_key  = prs80_pkg::key_fwd(key_in, RC_ENC);
        enc_data = prs80_pkg::perm_fwd(prs80_pkg::sub_fwd(data_in ^ prs80_pkg::top_key(key_in)));
        // last encrypt round also applies the closing key whitening
        if (LAST)
        begin
            enc_data = enc_data ^ prs80_pkg::top_key(enc_key);
        end

        dec_key  = prs80_pkg::key_bwd(key_in, RC_DEC);
        dec_data = prs80_pkg::sub_inv(prs80_pkg::perm_inv(data_in))
                   ^ prs80_pkg::top_key(dec_key);

        if (ctrl_in.kind == prs80_pkg::KIND_DECRYPT)
        begin
            data_next = dec_data;
            key_next  = dec_key;
        end
        else
        begin
            data_next = enc_data;
            key_next  = enc_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
            key_reg  <= key_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign data_out = data_reg;
    assign key_out  = key_reg;

endmodule

`default_nettype wire

@@ rtl/present80_block_cipher_core.sv @@
// PRESENT-80 block cipher core: key registers, input stage and unrolled round pipeline.
//
// Usage:
//   Input beats arrive on s_axis_*: tdata is the 64-bit block, tuser[0] selects
//   encrypt (0) or decrypt (1). Results leave on m_axis_*: tdata is the 64-bit
//   result block, one result per input beat, in input order.
//   The 80-bit key sits in two APB registers: key_low at address 0x0 and
//   key_high at 0x8 (only paddr[3] is decoded). For decryption load the key
//   register value after the last schedule update, not the user key.
//   Write the key only while no beat is in flight.
// Timing:
//   An input register plus one register stage per round lie between an input
//   beat and its output valid.
//   Every round has its own stage, so one beat enters per cycle when the
//   output is taken every cycle.
// Reset and stalls:
//   Reset clears all valid bits and both key registers. When m_axis_tready is
//   low with a result waiting, the round stages hold; the input stage still
//   takes one beat if it is empty, then s_axis_tready drops until the output
//   moves again. Nothing is dropped or repeated.
`default_nettype none

module present80_block_cipher_core #(
    parameter int unsigned ROUNDS = prs80_pkg::ROUNDS_DEFAULT
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // APB configuration port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [prs80_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire  [prs80_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [prs80_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    // input stream
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [63:0]                        s_axis_tdata,  // [63:0] block_in
    input  wire  [0:0]                         s_axis_tuser,  // [0] kind
    // output stream
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [63:0]                        m_axis_tdata   // [63:0] block_out
);

    logic [prs80_pkg::BLOCK_W-1:0]    key_low_reg;
    logic [prs80_pkg::KEY_HIGH_W-1:0] key_high_reg;
    prs80_pkg::key_t                  cfg_key;
    logic                             cfg_write;

    prs80_pkg::stage_ctrl_t           ctrl_q [0:ROUNDS];
    prs80_pkg::block_t                data_q [0:ROUNDS];
    prs80_pkg::key_t                  key_q  [0:ROUNDS];

    prs80_pkg::stage_ctrl_t           in_ctrl_reg;
    prs80_pkg::block_t                in_data_reg;
    prs80_pkg::block_t                in_data_next;
    prs80_pkg::key_t                  in_key_reg;

    logic                             advance;
    logic                             in_load;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_key   = {key_high_reg, key_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[prs80_pkg::APB_ADDR_W-1])
                prs80_pkg::REG_KEY_LOW:
                    key_low_reg  <= pwdata[prs80_pkg::BLOCK_W-1:0];
                prs80_pkg::REG_KEY_HIGH:
                    key_high_reg <= pwdata[prs80_pkg::KEY_HIGH_W-1:0];
                default:
                    key_low_reg  <= key_low_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[prs80_pkg::APB_ADDR_W-1])
            prs80_pkg::REG_KEY_LOW:
                prdata = key_low_reg;
            prs80_pkg::REG_KEY_HIGH:
                prdata = {{(prs80_pkg::APB_DATA_W - prs80_pkg::KEY_HIGH_W){1'b0}},
                          key_high_reg};
            default:
                prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // round stages move when the output is empty or taken; the input stage
    // may also fill a hole of its own during a stall
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign in_load       = advance || !in_ctrl_reg.valid;
    assign s_axis_tready = in_load;

    // ---------------- input stage ----------------
    // decryption starts with the whitening key XOR
    always_comb
    begin
        if (s_axis_tuser[0] == prs80_pkg::KIND_DECRYPT)
        begin
            in_data_next = s_axis_tdata ^ prs80_pkg::top_key(cfg_key);
        end
        else
        begin
            in_data_next = s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctrl_reg <= '0;
        end
        else if (in_load)
        begin
            in_ctrl_reg.valid <= s_axis_tvalid;
            in_ctrl_reg.kind  <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= in_data_next;
            in_key_reg  <= cfg_key;
        end
    end

    assign ctrl_q[0] = in_ctrl_reg;
    assign data_q[0] = in_data_reg;
    assign key_q[0]  = in_key_reg;

    // ---------------- round stages ----------------
    for (genvar s = 1; s <= ROUNDS; s++)
    begin : g_round
        prs80_round #(
            .RC_ENC (prs80_pkg::RC_W'(s)),
            .RC_DEC (prs80_pkg::RC_W'(ROUNDS + 1 - s)),
            .LAST   (s == ROUNDS)
        ) u_round (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .ctrl_in  (ctrl_q[s-1]),
            .data_in  (data_q[s-1]),
            .key_in   (key_q[s-1]),
            .ctrl_out (ctrl_q[s]),
            .data_out (data_q[s]),
            .key_out  (key_q[s])
        );
    end

    assign m_axis_tvalid = ctrl_q[ROUNDS].valid;
    assign m_axis_tdata  = data_q[ROUNDS];

`ifndef SYNTHESIS
    a_ready_when_out_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready
    ) else $error("input not ready while output stage is empty");

    a_accept_fills_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_ctrl_reg.valid
    ) else $error("accepted beat did not reach the input stage");

    a_input_holds_in_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_ctrl_reg.valid && !advance) |=>
            (in_ctrl_reg.valid && $stable(in_data_reg))
    ) else $error("input stage lost its beat during a stall");
`endif

endmodule

`default_nettype wire
